// ===== rtl/cmob_pkg.sv =====
// ----------------------------------------------------------------------------
// cmob_pkg
// Shared constants, codes and the sine table generator of the chaotic map
// oscillator bank.
// ----------------------------------------------------------------------------
package cmob_pkg;

	localparam int CHANNELS_DEF        = 16;
	localparam int PHASE_BITS_DEF      = 24;
	localparam int SINE_TABLE_BITS_DEF = 10;

	localparam int VALUE_W     = 18;   // signed Q1.16 map value
	localparam int HALF_VALUE  = 32768;

	localparam logic [1:0] MAP_LOGISTIC = 2'd0;
	localparam logic [1:0] MAP_TENT     = 2'd1;
	localparam logic [1:0] MAP_CIRCLE   = 2'd2;
	localparam logic [1:0] MAP_SAW      = 2'd3;

	localparam logic [1:0] CFG_MAP_MODE = 2'd0;
	localparam logic [1:0] CFG_CLOCKED  = 2'd1;

	// Quarter-wave odd polynomial sine in Q.16, evaluated at elaboration.
	function automatic longint sine_value(input int idx, input int tb);
		longint tt;
		longint q;
		longint f;
		longint z;
		longint z2;
		longint p;
		longint s;
		tt = longint'(idx) << (16 - tb);
		q  = tt >> 14;
		f  = tt & 64'h3FFF;
		if ((q & 1) != 0)
			f = 16384 - f;
		z  = f << 2;
		z2 = (z * z) >> 16;
		p  = 5223 - ((z2 * 307) >> 16);
		p  = 42334 - ((z2 * p) >> 16);
		p  = 102944 - ((z2 * p) >> 16);
		s  = (z * p) >> 16;
		return (q >= 2) ? -s : s;
	endfunction

endpackage

// ===== rtl/chaotic_map_oscillator_bank_unit.sv =====
// ----------------------------------------------------------------------------
// chaotic_map_oscillator_bank_unit
// Bank of chaotic map oscillators with state kept in a per-channel memory.
// ----------------------------------------------------------------------------
// Each input word addresses one channel and returns exactly one output word.
// Words are handled one at a time: read of the channel state from memory,
// two multiply steps for the map, one for the interpolation, then write back
// and output; the output step waits while the output side is not ready.
// The next word is accepted while an earlier output word waits to be taken.
// The state memory needs no clearing pass after reset.
module chaotic_map_oscillator_bank_unit #(
	parameter int CHANNELS        = cmob_pkg::CHANNELS_DEF,
	parameter int PHASE_BITS      = cmob_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = cmob_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [3:0]  channel,
	input  logic [15:0] chaos_amount,
	input  logic [23:0] phase_step,
	input  logic        step_pulse,
	input  logic [15:0] seed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  out_channel,
	output logic [15:0] out_value
);

	import cmob_pkg::*;

	localparam int AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ENTRY_W = 2 * VALUE_W + PHASE_BITS + 16;
	localparam int SINE_N  = 1 << SINE_TABLE_BITS;
	localparam int PH_UP   = (PHASE_BITS >= 24) ? PHASE_BITS - 24 : 0;
	localparam int PH_DN   = (PHASE_BITS >= 24) ? 0 : 24 - PHASE_BITS;
	localparam int P3_W    = PHASE_BITS + 20;
	localparam logic [ENTRY_W-1:0] RESET_WORD =
		{VALUE_W'(HALF_VALUE), VALUE_W'(HALF_VALUE), PHASE_BITS'(0), 16'(HALF_VALUE)};

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_MUL1, ST_MUL2, ST_FIN, ST_MUL3, ST_OUT
	} state_t;

	state_t state_q;

	logic [1:0]  map_mode_q;
	logic        clocked_q;

	logic        req_q;
	logic        inrange_q;
	logic [3:0]  ch_q;
	logic [15:0] amt_q;
	logic [23:0] step_q;
	logic        pulse_q;
	logic [15:0] seed_q;

	logic signed [VALUE_W-1:0] x_q;
	logic signed [VALUE_W-1:0] prev_q;
	logic signed [VALUE_W-1:0] cur_q;
	logic [PHASE_BITS-1:0]     ph_q;
	logic [15:0]               held_q;
	logic                      iter_q;
	logic signed [17:0]        sine_q;

	logic signed [39:0]   prod1_q;
	logic signed [56:0]   prod2_q;
	logic signed [P3_W-1:0] prod3_q;

	logic signed [17:0] sine_lut [SINE_N];

	for (genvar i = 0; i < SINE_N; i++) begin : g_sine
		assign sine_lut[i] = 18'(sine_value(i, SINE_TABLE_BITS));
	end

	// ---------------- state memory ----------------
	logic               accept;
	logic               wr_en;
	logic [ENTRY_W-1:0] rd_data;
	logic [ENTRY_W-1:0] wr_data;
	logic               out_load;

	cmob_state_ram #(
		.DEPTH      (CHANNELS),
		.AW         (AW),
		.DW         (ENTRY_W),
		.RESET_WORD (RESET_WORD)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (AW'(channel)),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (AW'(ch_q)),
		.wr_data (wr_data)
	);

	// ---------------- helpers ----------------
	function automatic logic signed [VALUE_W-1:0] sat18(input logic signed [56:0] v);
		if (v > 57'sd131071)
			return 18'sd131071;
		if (v < -57'sd131072)
			return -18'sd131072;
		return VALUE_W'(v);
	endfunction

	function automatic logic signed [VALUE_W-1:0] tmod16(input logic signed [39:0] v);
		logic [39:0] mag;
		logic [16:0] m;
		mag = (v < 0) ? 40'(-v) : 40'(v);
		m   = {1'b0, mag[15:0]};
		return (v < 0) ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

	function automatic logic [15:0] map_out(input logic signed [19:0] v,
	                                        input logic [1:0] mode);
		logic signed [20:0] w;
		w = 21'(v);
		if (mode == MAP_CIRCLE)
			w = (w + 21'sd65536) >>> 1;
		if (w > 21'sd65535)
			return 16'hFFFF;
		if (w < 0)
			return 16'h0000;
		return w[15:0];
	endfunction

	// ---------------- read stage ----------------
	logic signed [VALUE_W-1:0] rd_prev;
	logic signed [VALUE_W-1:0] rd_cur;
	logic [PHASE_BITS-1:0]     rd_ph;
	logic [15:0]               rd_held;
	logic [PHASE_BITS+24:0]    step_wide;
	logic [PHASE_BITS:0]       ph_sum;
	logic                      do_iter;

	always_comb begin
		{rd_prev, rd_cur, rd_ph, rd_held} = rd_data;
		step_wide = ((PHASE_BITS + 25)'(step_q) << PH_UP) >> PH_DN;
		ph_sum    = {1'b0, rd_ph} + {1'b0, step_wide[PHASE_BITS-1:0]};
		do_iter   = !req_q && inrange_q && (clocked_q ? pulse_q : ph_sum[PHASE_BITS]);
	end

	// ---------------- map multiply steps ----------------
	logic signed [39:0] x40;
	logic signed [39:0] mul1;
	logic [17:0]        r_tent;
	logic signed [18:0] m_tent;
	logic [18:0]        r_log;
	logic [18:0]        r_saw;
	logic signed [56:0] mul2;
	logic signed [VALUE_W-1:0] y_map;
	logic signed [39:0] csum;
	logic signed [VALUE_W-1:0] tsaw;

	always_comb begin
		x40    = 40'(x_q);
		r_tent = 18'd65536 + 18'(amt_q);
		if (r_tent >= 18'd131072)
			r_tent = 18'd131065;
		m_tent = (x_q < 18'sd32768) ? 19'(x_q) : 19'sd65536 - 19'(x_q);
		case (map_mode_q)
			MAP_LOGISTIC: mul1 = x40 * (40'sd65536 - x40);
			MAP_TENT:     mul1 = $signed({22'b0, r_tent}) * 40'(m_tent);
			MAP_CIRCLE:   mul1 = $signed({23'b0, amt_q, 1'b0}) * 40'(sine_q);
			default:      mul1 = $signed({24'b0, amt_q}) * 40'sd196606;
		endcase

		r_log = 19'd196608 + 19'(amt_q);
		r_saw = 19'd65537 + 19'(prod1_q[33:16]);
		if (r_saw == 19'd131072)
			r_saw = 19'd131073;
		case (map_mode_q)
			MAP_LOGISTIC: mul2 = 57'(prod1_q) * $signed({38'b0, r_log});
			MAP_SAW:      mul2 = $signed({38'b0, r_saw}) * 57'(x_q);
			default:      mul2 = 57'(prod1_q);
		endcase

		csum = 40'(x_q) + 40'sd21845 + 40'(prod2_q >>> 16);
		tsaw = tmod16(40'(prod2_q >>> 16));
		if (tsaw == 0)
			tsaw = 18'sd1;
		case (map_mode_q)
			MAP_LOGISTIC: y_map = sat18(prod2_q >>> 32);
			MAP_TENT:     y_map = sat18(prod2_q >>> 16);
			MAP_CIRCLE:   y_map = tmod16(csum);
			default:      y_map = tsaw;
		endcase
	end

	// ---------------- interpolation and output ----------------
	logic signed [18:0]     diff;
	logic signed [19:0]     v_lin;
	logic [15:0]            result;

	always_comb begin
		diff  = 19'(cur_q) - 19'(prev_q);
		v_lin = 20'(prev_q) + 20'(prod3_q >>> PHASE_BITS);
		if (!inrange_q)
			result = 16'h0000;
		else if (req_q)
			result = seed_q;
		else if (clocked_q)
			result = pulse_q ? map_out(20'(cur_q), map_mode_q) : held_q;
		else
			result = map_out(v_lin, map_mode_q);
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_load  = (state_q == ST_OUT) && (!out_valid || out_ready);
	assign wr_en     = out_load && inrange_q;
	assign wr_data   = {prev_q, cur_q, ph_q, result};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			map_mode_q <= MAP_LOGISTIC;
			clocked_q  <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MAP_MODE: map_mode_q <= cfg_data;
					CFG_CLOCKED:  clocked_q  <= cfg_data[0];
					default:      ;
				endcase
			end
			if (out_load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_READ;
				ST_READ: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_FIN;
				ST_FIN:  state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					req_q     <= req_type;
					inrange_q <= 32'(channel) < CHANNELS;
					ch_q      <= channel;
					amt_q     <= chaos_amount;
					step_q    <= phase_step;
					pulse_q   <= step_pulse;
					seed_q    <= seed;
				end
			end
			ST_READ: begin
				x_q    <= rd_cur;
				sine_q <= sine_lut[rd_cur[15:16-SINE_TABLE_BITS]];
				held_q <= rd_held;
				iter_q <= do_iter;
				if (req_q) begin
					prev_q <= VALUE_W'({2'b0, seed_q});
					cur_q  <= VALUE_W'({2'b0, seed_q});
					ph_q   <= '0;
				end else begin
					prev_q <= rd_prev;
					cur_q  <= rd_cur;
					ph_q   <= clocked_q ? rd_ph : ph_sum[PHASE_BITS-1:0];
				end
			end
			ST_MUL1: prod1_q <= mul1;
			ST_MUL2: prod2_q <= mul2;
			ST_FIN: begin
				if (iter_q) begin
					prev_q <= x_q;
					cur_q  <= y_map;
				end
			end
			ST_MUL3: prod3_q <= P3_W'(diff) * $signed({1'b0, ph_q});
			ST_OUT: begin
				if (out_load) begin
					out_channel <= ch_q;
					out_value   <= result;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/cmob_state_ram.sv =====
// ----------------------------------------------------------------------------
// cmob_state_ram
// Per-channel state memory, one read and one write port, registered read.
// Entries never written since reset read as the reset word.
// ----------------------------------------------------------------------------
module cmob_state_ram #(
	parameter int          DEPTH      = 16,
	parameter int          AW         = 4,
	parameter int          DW         = 76,
	parameter logic [DW-1:0] RESET_WORD = '0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0]    mem [DEPTH];
	logic [DW-1:0]    rd_word_q;
	logic             rd_valid_q;
	logic [DEPTH-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_word_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en)
				valid_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_word_q : RESET_WORD;

endmodule
